@@ design/ssp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite screen projection package
// Fixed widths of the projection datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

	// Map positions, unsigned Q16.16.
	localparam int POS_W   = 32;
	// Camera vectors, signed Q2.16.
	localparam int VEC_W   = 18;
	// Signed offset between two positions.
	localparam int OFS_W   = POS_W + 1;
	// Fraction bits of the fixed-point formats.
	localparam int FRAC_W  = 16;
	// Camera-space coordinates, signed Q16.16.
	localparam int DEPTH_W = 32;
	// Screen column and sprite size.
	localparam int COL_W   = 16;
	localparam int SIZE_W  = 16;
	// Signed products and sums of the camera transform.
	localparam int PROD_W  = OFS_W + VEC_W;
	localparam int NUM_W   = PROD_W + 1;
	localparam int NMAG_W  = NUM_W - 1;
	localparam int DPROD_W = 2 * VEC_W;
	localparam int DET_W   = DPROD_W + 1;
	localparam int DMAG_W  = DET_W - 1;
	// Squared offset length, exact at Q32.32.
	localparam int SQ_W    = 2 * POS_W;

	typedef logic signed [DEPTH_W-1:0] coord_t;

endpackage

@@ design/ssp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with an overflow flag when
// the quotient does not fit in QW bits.
// ----------------------------------------------------------------------------
module ssp_div #(
	parameter int NW = 67,
	parameter int DW = 36,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] out_side
);

	logic             v_s    [0:QW];
	logic [DW-1:0]    rem_s  [0:QW];
	logic [QW-1:0]    low_s  [0:QW];
	logic [DW-1:0]    d_s    [0:QW];
	logic             ovf_s  [0:QW];
	logic [SW-1:0]    side_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	// The upper numerator bits seed the remainder; if they already reach the
	// divisor, the quotient is too wide.
	always_ff @(posedge clk) begin
		rem_s[0]  <= DW'(num[NW-1:QW]);
		low_s[0]  <= num[QW-1:0];
		d_s[0]    <= den;
		ovf_s[0]  <= (num[NW-1:QW] >= den);
		side_s[0] <= in_side;
	end

	genvar k;
	for (k = 1; k <= QW; k++) begin : g_step
		logic [DW:0]   trial;
		logic          ge;
		logic [DW-1:0] rem_n;

		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][QW-1]};
			ge    = (trial >= {1'b0, d_s[k-1]});
			rem_n = ge ? DW'(trial - {1'b0, d_s[k-1]}) : trial[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		// Numerator bits leave at the top while quotient bits enter at the bottom.
		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_n;
			low_s[k]  <= {low_s[k-1][QW-2:0], ge};
			d_s[k]    <= d_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = low_s[QW];
	assign ovf       = ovf_s[QW];
	assign out_side  = side_s[QW];

endmodule

@@ design/sprite_screen_projection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite screen projection
// Projects one sprite into screen space for a raycaster: near test, camera
// transform, depth, centre column, size and the clamped draw rectangle.
// ----------------------------------------------------------------------------
// Usage. A request is taken at each rising edge with start high and busy low.
// busy stays low: the datapath is a free-running pipeline and takes a new
// request in every cycle, so one sprite per clock is sustained.
// Each request gives exactly one result, shown for one cycle with done high.
// Results leave in request order.
// The depth of the pipeline comes from two chained dividers: the camera
// transform divides by the determinant with one quotient bit per stage
// (33 stages), and the column and size divide by the depth (17 stages).
// The receiver cannot stall, so the pipeline never holds.
// near_distance is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high. Write it only while no request is in flight.
// Reset clears every valid bit in the pipeline and sets near_distance to 2.0.
// When divide_error is high all geometric outputs read zero; near_flag
// still holds.
// ----------------------------------------------------------------------------
module sprite_screen_projection #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request channel.
	input  logic                               start,
	output logic                               busy,
	input  logic [ssp_pkg::POS_W-1:0]          sprite_x,
	input  logic [ssp_pkg::POS_W-1:0]          sprite_y,
	input  logic [ssp_pkg::POS_W-1:0]          cam_x,
	input  logic [ssp_pkg::POS_W-1:0]          cam_y,
	input  logic signed [ssp_pkg::VEC_W-1:0]   dir_x,
	input  logic signed [ssp_pkg::VEC_W-1:0]   dir_y,
	input  logic signed [ssp_pkg::VEC_W-1:0]   plane_x,
	input  logic signed [ssp_pkg::VEC_W-1:0]   plane_y,
	// Configuration channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssp_pkg::POS_W-1:0]          cfg_data,
	// Result channel.
	output logic                               done,
	output logic                               near_flag,
	output logic signed [ssp_pkg::DEPTH_W-1:0] depth,
	output logic                               in_front,
	output logic signed [ssp_pkg::COL_W-1:0]   screen_column,
	output logic [ssp_pkg::SIZE_W-1:0]         sprite_size,
	output logic [14:0]                        start_x,
	output logic signed [15:0]                 end_x,
	output logic [8:0]                         start_y,
	output logic [8:0]                         end_y,
	output logic                               divide_error
);

	localparam int OFS_W   = ssp_pkg::OFS_W;
	localparam int VEC_W   = ssp_pkg::VEC_W;
	localparam int PROD_W  = ssp_pkg::PROD_W;
	localparam int NUM_W   = ssp_pkg::NUM_W;
	localparam int NMAG_W  = ssp_pkg::NMAG_W;
	localparam int DPROD_W = ssp_pkg::DPROD_W;
	localparam int DET_W   = ssp_pkg::DET_W;
	localparam int DMAG_W  = ssp_pkg::DMAG_W;
	localparam int SQ_W    = ssp_pkg::SQ_W;
	localparam int FRAC_W  = ssp_pkg::FRAC_W;
	localparam int DEPTH_W = ssp_pkg::DEPTH_W;
	localparam int COL_W   = ssp_pkg::COL_W;
	localparam int SIZE_W  = ssp_pkg::SIZE_W;

	// Transform divider: |numerator| << 16 over |det|, 32 quotient bits.
	localparam int TNW = NMAG_W + FRAC_W;
	localparam int TQW = DEPTH_W;
	// Second divider pair: 16 quotient bits over |depth|.
	localparam int HALF_W = SCREEN_WIDTH / 2;
	localparam int HWB    = $clog2(HALF_W + 1);
	localparam int TS_W   = DEPTH_W + 1;
	localparam int CNW    = TS_W + HWB;
	localparam int HHB    = $clog2(SCREEN_HEIGHT + 1);
	localparam int SNW    = HHB + FRAC_W;
	localparam logic [SNW-1:0] SIZE_NUM = SNW'(SCREEN_HEIGHT) << FRAC_W;
	localparam int RW     = SIZE_W + 2;

	// The receiver never stalls and the pipeline always moves.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Near distance register.
	logic [ssp_pkg::POS_W-1:0] near_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_dist_q <= ssp_pkg::POS_W'(131072);
		end else if (cfg_valid && cfg_ready) begin
			near_dist_q <= cfg_data;
		end
	end

	// Stage 1: capture the request and form the exact signed offset.
	logic                    v_s1;
	logic signed [OFS_W-1:0] rx_s1, ry_s1;
	logic signed [VEC_W-1:0] dx_s1, dy_s1, px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		rx_s1 <= $signed({1'b0, sprite_x}) - $signed({1'b0, cam_x});
		ry_s1 <= $signed({1'b0, sprite_y}) - $signed({1'b0, cam_y});
		dx_s1 <= dir_x;
		dy_s1 <= dir_y;
		px_s1 <= plane_x;
		py_s1 <= plane_y;
	end

	// Stage 2: all products. The squares of signed offsets are never negative
	// and stay below 2^64.
	logic                      v_s2;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2, nd2_s2;
	logic signed [PROD_W-1:0]  dyrx_s2, dxry_s2, pyrx_s2, pxry_s2;
	logic signed [DPROD_W-1:0] pxdy_s2, dxpy_s2;
	logic signed [2*OFS_W-1:0] sqx_w, sqy_w;
	logic signed [PROD_W-1:0]  dyrx_w, dxry_w, pyrx_w, pxry_w;
	logic signed [DPROD_W-1:0] pxdy_w, dxpy_w;

	always_comb begin
		sqx_w  = rx_s1 * rx_s1;
		sqy_w  = ry_s1 * ry_s1;
		dyrx_w = dy_s1 * rx_s1;
		dxry_w = dx_s1 * ry_s1;
		pyrx_w = py_s1 * rx_s1;
		pxry_w = px_s1 * ry_s1;
		pxdy_w = px_s1 * dy_s1;
		dxpy_w = dx_s1 * py_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= sqx_w[SQ_W-1:0];
		sqy_s2  <= sqy_w[SQ_W-1:0];
		nd2_s2  <= near_dist_q * near_dist_q;
		dyrx_s2 <= dyrx_w;
		dxry_s2 <= dxry_w;
		pyrx_s2 <= pyrx_w;
		pxry_s2 <= pxry_w;
		pxdy_s2 <= pxdy_w;
		dxpy_s2 <= dxpy_w;
	end

	// Stage 3: the squared length keeps its carry, so an overflow past 64 bits
	// can never compare below the threshold.
	logic                     v_s3;
	logic [SQ_W:0]            sum_s3;
	logic [SQ_W-1:0]          nd2_s3;
	logic signed [NUM_W-1:0]  nx_s3, ny_s3;
	logic signed [DET_W-1:0]  det_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		nd2_s3 <= nd2_s2;
		nx_s3  <= NUM_W'(dyrx_s2) - NUM_W'(dxry_s2);
		ny_s3  <= NUM_W'(pxry_s2) - NUM_W'(pyrx_s2);
		det_s3 <= DET_W'(pxdy_s2) - DET_W'(dxpy_s2);
	end

	// Stage 4: near compare, magnitudes and quotient signs.
	logic              v_s4;
	logic              near_s4, detz_s4, nxneg_s4, nyneg_s4;
	logic [NMAG_W-1:0] nxm_s4, nym_s4;
	logic [DMAG_W-1:0] detm_s4;
	logic [NUM_W-1:0]  nxa_w, nya_w;
	logic [DET_W-1:0]  deta_w;

	always_comb begin
		nxa_w  = nx_s3[NUM_W-1] ? NUM_W'(-nx_s3) : NUM_W'(nx_s3);
		nya_w  = ny_s3[NUM_W-1] ? NUM_W'(-ny_s3) : NUM_W'(ny_s3);
		deta_w = det_s3[DET_W-1] ? DET_W'(-det_s3) : DET_W'(det_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		near_s4  <= (sum_s3 < {1'b0, nd2_s3});
		detz_s4  <= (det_s3 == '0);
		nxneg_s4 <= nx_s3[NUM_W-1] ^ det_s3[DET_W-1];
		nyneg_s4 <= ny_s3[NUM_W-1] ^ det_s3[DET_W-1];
		nxm_s4   <= nxa_w[NMAG_W-1:0];
		nym_s4   <= nya_w[NMAG_W-1:0];
		detm_s4  <= deta_w[DMAG_W-1:0];
	end

	// Camera transform dividers, one for each axis.
	logic           tx_v, ty_v, tx_ovf, ty_ovf;
	logic [TQW-1:0] tx_q, ty_q;
	logic           tx_side;
	logic [2:0]     ty_side;

	ssp_div #(.NW(TNW), .DW(DMAG_W), .QW(TQW), .SW(1)) u_div_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.num      ({nxm_s4, FRAC_W'(0)}),
		.den      (detm_s4),
		.in_side  (nxneg_s4),
		.out_valid(tx_v),
		.quo      (tx_q),
		.ovf      (tx_ovf),
		.out_side (tx_side)
	);

	ssp_div #(.NW(TNW), .DW(DMAG_W), .QW(TQW), .SW(3)) u_div_ty (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.num      ({nym_s4, FRAC_W'(0)}),
		.den      (detm_s4),
		.in_side  ({nyneg_s4, near_s4, detz_s4}),
		.out_valid(ty_v),
		.quo      (ty_q),
		.ovf      (ty_ovf),
		.out_side (ty_side)
	);

	// Stage 5: saturate both quotients to 32 bit signed and apply the sign.
	logic               v_s5, near_s5, detz_s5;
	ssp_pkg::coord_t    tx_s5, ty_s5;
	logic [TQW-1:0]     capx_w, capy_w, mx_w, my_w;

	always_comb begin
		capx_w = tx_side ? TQW'(33'h0_8000_0000) : TQW'(33'h0_7FFF_FFFF);
		capy_w = ty_side[2] ? TQW'(33'h0_8000_0000) : TQW'(33'h0_7FFF_FFFF);
		mx_w   = (tx_ovf || tx_q > capx_w) ? capx_w : tx_q;
		my_w   = (ty_ovf || ty_q > capy_w) ? capy_w : ty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= ty_v && tx_v;
		end
	end

	always_ff @(posedge clk) begin
		tx_s5   <= tx_side ? $signed(-mx_w) : $signed(mx_w);
		ty_s5   <= ty_side[2] ? $signed(-my_w) : $signed(my_w);
		near_s5 <= ty_side[1];
		detz_s5 <= ty_side[0];
	end

	// Stage 6: the column numerator sum and the final error decision.
	logic                   v_s6, near_s6, err_s6, front_s6;
	logic signed [TS_W-1:0] tsum_s6;
	ssp_pkg::coord_t        ty_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		tsum_s6  <= TS_W'(tx_s5) + TS_W'(ty_s5);
		ty_s6    <= ty_s5;
		near_s6  <= near_s5;
		err_s6   <= detz_s5 || (ty_s5 == '0);
		front_s6 <= (ty_s5 > 0);
	end

	// Stage 7: magnitudes for the second divider pair.
	logic                 v_s7, near_s7, err_s7, front_s7, cneg_s7;
	logic [TS_W-1:0]      tsm_s7;
	logic [DEPTH_W-1:0]   tym_s7;
	ssp_pkg::coord_t      ty_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		tsm_s7   <= tsum_s6[TS_W-1] ? TS_W'(-tsum_s6) : TS_W'(tsum_s6);
		tym_s7   <= ty_s6[DEPTH_W-1] ? DEPTH_W'(-ty_s6) : DEPTH_W'(ty_s6);
		cneg_s7  <= tsum_s6[TS_W-1] ^ ty_s6[DEPTH_W-1];
		ty_s7    <= ty_s6;
		near_s7  <= near_s6;
		err_s7   <= err_s6;
		front_s7 <= front_s6;
	end

	// Stage 8: scale the column numerator by half the screen width.
	logic                 v_s8, near_s8, err_s8, front_s8, cneg_s8;
	logic [CNW-1:0]       cnum_s8;
	logic [DEPTH_W-1:0]   tym_s8;
	ssp_pkg::coord_t      ty_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		cnum_s8  <= CNW'(tsm_s7) * CNW'(HALF_W);
		tym_s8   <= tym_s7;
		cneg_s8  <= cneg_s7;
		ty_s8    <= ty_s7;
		near_s8  <= near_s7;
		err_s8   <= err_s7;
		front_s8 <= front_s7;
	end

	// Column and size dividers, both over the depth magnitude.
	logic                     col_v, size_v, col_ovf, size_ovf;
	logic [COL_W-1:0]         col_q;
	logic [SIZE_W-1:0]        size_q;
	logic [DEPTH_W+2:0]       col_side;
	logic                     size_side;

	ssp_div #(.NW(CNW), .DW(DEPTH_W), .QW(COL_W), .SW(DEPTH_W + 3)) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s8),
		.num      (cnum_s8),
		.den      (tym_s8),
		.in_side  ({cneg_s8, ty_s8, near_s8, front_s8}),
		.out_valid(col_v),
		.quo      (col_q),
		.ovf      (col_ovf),
		.out_side (col_side)
	);

	ssp_div #(.NW(SNW), .DW(DEPTH_W), .QW(SIZE_W), .SW(1)) u_div_size (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s8),
		.num      (SIZE_NUM),
		.den      (tym_s8),
		.in_side  (err_s8),
		.out_valid(size_v),
		.quo      (size_q),
		.ovf      (size_ovf),
		.out_side (size_side)
	);

	// Stage 9: saturate the column to 16 bit signed and the size to 16 bits.
	logic                      v_s9, near_s9, err_s9, front_s9;
	logic signed [COL_W-1:0]   col_s9;
	logic [SIZE_W-1:0]         size_s9;
	ssp_pkg::coord_t           ty_s9;
	logic [COL_W:0]            ccap_w, cm_w;

	always_comb begin
		ccap_w = col_side[DEPTH_W+2] ? (COL_W+1)'(32768) : (COL_W+1)'(32767);
		cm_w   = (col_ovf || {1'b0, col_q} > ccap_w) ? ccap_w : {1'b0, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= col_v && size_v;
		end
	end

	always_ff @(posedge clk) begin
		col_s9   <= col_side[DEPTH_W+2] ? $signed(COL_W'(-cm_w)) : $signed(cm_w[COL_W-1:0]);
		size_s9  <= size_ovf ? '1 : size_q;
		ty_s9    <= col_side[DEPTH_W+1:2];
		near_s9  <= col_side[1];
		front_s9 <= col_side[0];
		err_s9   <= size_side;
	end

	// Stage 10: draw rectangle, error masking and the result register.
	logic signed [RW-1:0] half_w, sxs_w, exs_w, sys_w, eys_w;
	logic [14:0]          sx_w;
	logic signed [15:0]   ex_w;
	logic [8:0]           sy_w, ey_w;

	always_comb begin
		half_w = $signed(RW'({1'b0, size_s9[SIZE_W-1:1]}));
		sxs_w  = RW'(col_s9) - half_w;
		exs_w  = RW'(col_s9) + half_w;
		sys_w  = $signed(RW'(SCREEN_HEIGHT)) - $signed(RW'(size_s9));
		eys_w  = ($signed(RW'(SCREEN_HEIGHT)) + $signed(RW'(size_s9))) >>> 1;
		sx_w   = (sxs_w < 0) ? '0 : sxs_w[14:0];
		if (exs_w >= $signed(RW'(SCREEN_WIDTH))) begin
			ex_w = 16'(SCREEN_WIDTH - 1);
		end else if (exs_w < $signed(RW'(-32768))) begin
			ex_w = 16'sh8000;
		end else begin
			ex_w = exs_w[15:0];
		end
		// Bits 9..1 of a non-negative value are its floor half.
		sy_w   = (sys_w < 0) ? '0 : sys_w[9:1];
		ey_w   = (eys_w >= $signed(RW'(SCREEN_HEIGHT))) ? 9'(SCREEN_HEIGHT - 1) : eys_w[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s9;
		end
	end

	// A zero divisor forces every geometric field to zero.
	always_ff @(posedge clk) begin
		near_flag     <= near_s9;
		divide_error  <= err_s9;
		depth         <= err_s9 ? '0 : ty_s9;
		in_front      <= !err_s9 && front_s9;
		screen_column <= err_s9 ? '0 : col_s9;
		sprite_size   <= err_s9 ? '0 : size_s9;
		start_x       <= err_s9 ? '0 : sx_w;
		end_x         <= err_s9 ? '0 : ex_w;
		start_y       <= err_s9 ? '0 : sy_w;
		end_y         <= err_s9 ? '0 : ey_w;
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite projection testbench
// Drives sprite and camera requests into the projection pipeline, predicts
// the results with an independent fixed-point model of the camera transform
// or takes them typed in, and compares them field by field, in request order.
// ----------------------------------------------------------------------------
module tb;

	localparam int SCR_W     = 1024;
	localparam int SCR_H     = 512;
	localparam int PIPE_LAT  = 60;
	localparam int N_RANDOM  = 700;
	localparam logic [31:0] NEAR_RESET = 32'h0002_0000;

	// One projected sprite as it leaves the block.
	typedef struct packed {
		logic               near_flag;
		logic signed [31:0] depth;
		logic               in_front;
		logic signed [15:0] screen_column;
		logic [15:0]        sprite_size;
		logic [14:0]        start_x;
		logic signed [15:0] end_x;
		logic [8:0]         start_y;
		logic [8:0]         end_y;
		logic               divide_error;
	} projection_t;

	// One sprite request.
	typedef struct packed {
		logic [31:0]        spr_x;
		logic [31:0]        spr_y;
		logic [31:0]        eye_x;
		logic [31:0]        eye_y;
		logic signed [17:0] d_x;
		logic signed [17:0] d_y;
		logic signed [17:0] p_x;
		logic signed [17:0] p_y;
	} sprite_req_t;

	// Directed row: the request, and the projection when it is obvious.
	typedef struct {
		sprite_req_t req;
		bit          typed;
		projection_t proj;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] sprite_x = '0, sprite_y = '0, cam_x = '0, cam_y = '0;
	logic signed [17:0] dir_x = '0, dir_y = '0, plane_x = '0, plane_y = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;
	logic done, near_flag, in_front, divide_error;
	logic signed [31:0] depth;
	logic signed [15:0] screen_column, end_x;
	logic [15:0] sprite_size;
	logic [14:0] start_x;
	logic [8:0] start_y, end_y;

	sprite_screen_projection #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) DUT (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.sprite_x(sprite_x), .sprite_y(sprite_y), .cam_x(cam_x), .cam_y(cam_y),
		.dir_x(dir_x), .dir_y(dir_y), .plane_x(plane_x), .plane_y(plane_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .near_flag(near_flag), .depth(depth), .in_front(in_front),
		.screen_column(screen_column), .sprite_size(sprite_size),
		.start_x(start_x), .end_x(end_x), .start_y(start_y), .end_y(end_y),
		.divide_error(divide_error)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Model copy of the near distance register.
	logic [31:0] near_dist_model;
	// Projections waiting for the pipeline to deliver them, oldest first.
	projection_t pending_proj[$];
	int mismatches = 0;
	int n_results = 0;
	int n_errors_seen = 0;
	int n_near_seen = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// floor(n * 2^s / d) capped at cap; the cap keeps the value in range.
	function automatic logic [63:0] quot_capped(input logic [63:0] n, input int s,
			input logic [63:0] d, input logic [63:0] cap);
		logic [127:0] q;
		q = ({64'd0, n} << s) / {64'd0, d};
		return (q > {64'd0, cap}) ? cap : q[63:0];
	endfunction

	// Signed division rounded toward zero, saturated to [-capneg, cappos].
	function automatic longint sat_quot(input longint n, input int s, input longint d,
			input logic [63:0] cappos, input logic [63:0] capneg);
		bit neg;
		logic [63:0] m;
		neg = (n < 0) != (d < 0);
		m = quot_capped(n < 0 ? -n : n, s, d < 0 ? -d : d, neg ? capneg : cappos);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic projection_t project_sprite(input sprite_req_t r);
		projection_t p;
		longint rx, ry, dx, dy, px, py, det, nx, ny, tx, ty, col, sz, half, sxs, exs;
		logic [63:0] ax, ay, sq_x, sq_sum, nd2;
		p = '0;
		rx = longint'({32'd0, r.spr_x}) - longint'({32'd0, r.eye_x});
		ry = longint'({32'd0, r.spr_y}) - longint'({32'd0, r.eye_y});
		dx = r.d_x; dy = r.d_y; px = r.p_x; py = r.p_y;
		ax = rx < 0 ? -rx : rx;
		ay = ry < 0 ? -ry : ry;
		sq_x = ax * ax;
		sq_sum = sq_x + ay * ay;
		nd2 = {32'd0, near_dist_model} * {32'd0, near_dist_model};
		// A squared length that wraps past 64 bits never counts as near.
		p.near_flag = (sq_sum >= sq_x) && (sq_sum < nd2);
		p.divide_error = 1'b1;
		det = px * dy - dx * py;
		if (det != 0) begin
			nx = dy * rx - dx * ry;
			ny = -py * rx + px * ry;
			tx = sat_quot(nx, 16, det, 64'h7FFF_FFFF, 64'h8000_0000);
			ty = sat_quot(ny, 16, det, 64'h7FFF_FFFF, 64'h8000_0000);
			if (ty != 0) begin
				p.divide_error = 1'b0;
				p.depth = ty[31:0];
				p.in_front = ty > 0;
				sz = longint'(quot_capped(SCR_H, 16, ty < 0 ? -ty : ty, 65535));
				col = sat_quot((SCR_W / 2) * (tx + ty), 0, ty, 32767, 32768);
				p.sprite_size = sz[15:0];
				p.screen_column = col[15:0];
				p.start_y = (SCR_H - sz < 0) ? 9'd0 : 9'((SCR_H - sz) / 2);
				p.end_y = ((SCR_H + sz) / 2 >= SCR_H) ? 9'(SCR_H - 1) : 9'((SCR_H + sz) / 2);
				half = sz / 2;
				sxs = col - half;
				p.start_x = sxs < 0 ? 15'd0 : sxs[14:0];
				exs = col + half;
				if (exs >= SCR_W)
					exs = SCR_W - 1;
				if (exs < -32768)
					exs = -32768;
				p.end_x = exs[15:0];
			end
		end
		return p;
	endfunction

	task automatic write_near_distance(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		near_dist_model = v;
	endtask

	// Holds start high until the request is taken, then may lower start before returning.
	// The expectation is queued as the request is taken.
	task automatic send_sprite(input sprite_req_t r, input bit typed,
			input projection_t given);
		int gap;
		sprite_x <= r.spr_x; sprite_y <= r.spr_y;
		cam_x <= r.eye_x; cam_y <= r.eye_y;
		dir_x <= r.d_x; dir_y <= r.d_y;
		plane_x <= r.p_x; plane_y <= r.p_y;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_proj.push_back(typed ? given : project_sprite(r));
		gap = $urandom_range(0, 3);
		// Runs of back-to-back requests, so the pipeline also sees full rate.
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lets the pipeline drain and then the settling time past it.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_proj.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	// Result side: the block presents one projection per done cycle.
	always @(posedge clk) begin
		projection_t want;
		projection_t got;
		if (arst_n && done) begin
			got = '{near_flag, depth, in_front, screen_column, sprite_size,
				start_x, end_x, start_y, end_y, divide_error};
			n_results++;
			if (divide_error)
				n_errors_seen++;
			if (near_flag)
				n_near_seen++;
			if (pending_proj.size() == 0) begin
				report_mismatch("unexpected result", 64'(got.depth), 64'd0);
			end else begin
				want = pending_proj.pop_front();
				if (got.near_flag !== want.near_flag)
					report_mismatch("near_flag", 64'(got.near_flag), 64'(want.near_flag));
				if (got.depth !== want.depth)
					report_mismatch("depth", 64'(got.depth), 64'(want.depth));
				if (got.in_front !== want.in_front)
					report_mismatch("in_front", 64'(got.in_front), 64'(want.in_front));
				if (got.screen_column !== want.screen_column)
					report_mismatch("screen_column", 64'(got.screen_column),
						64'(want.screen_column));
				if (got.sprite_size !== want.sprite_size)
					report_mismatch("sprite_size", 64'(got.sprite_size),
						64'(want.sprite_size));
				if (got.start_x !== want.start_x)
					report_mismatch("start_x", 64'(got.start_x), 64'(want.start_x));
				if (got.end_x !== want.end_x)
					report_mismatch("end_x", 64'(got.end_x), 64'(want.end_x));
				if (got.start_y !== want.start_y)
					report_mismatch("start_y", 64'(got.start_y), 64'(want.start_y));
				if (got.end_y !== want.end_y)
					report_mismatch("end_y", 64'(got.end_y), 64'(want.end_y));
				if (got.divide_error !== want.divide_error)
					report_mismatch("divide_error", 64'(got.divide_error),
						64'(want.divide_error));
			end
		end
	end

	function automatic logic signed [17:0] rand_vec();
		case ($urandom_range(0, 4))
			0: return 18'sh20000;
			1: return 18'sh1FFFF;
			2: return 18'($urandom_range(0, 3)) - 18'sd1;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0};
			default: return 32'h0080_0000 + ($urandom & 32'h003F_FFFF);
		endcase
	endfunction

	// Mostly a sensible camera: sprite near the camera, a random direction and
	// a perpendicular plane with random scale. The rest is free noise.
	function automatic sprite_req_t rand_sprite();
		sprite_req_t r;
		int sel;
		sel = $urandom_range(0, 9);
		r.eye_x = rand_pos();
		r.eye_y = rand_pos();
		if (sel < 7) begin
			r.spr_x = r.eye_x + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			r.spr_y = r.eye_y + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			r.d_x = 18'($signed($urandom_range(0, 32'h20000)) - 32'sh10000);
			r.d_y = 18'($signed($urandom_range(0, 32'h20000)) - 32'sh10000);
			r.p_x = -(r.d_y >>> $urandom_range(0, 3));
			r.p_y = r.d_x >>> $urandom_range(0, 3);
		end else begin
			r.spr_x = rand_pos();
			r.spr_y = rand_pos();
			r.d_x = rand_vec();
			r.d_y = rand_vec();
			r.p_x = rand_vec();
			r.p_y = rand_vec();
		end
		return r;
	endfunction

	localparam projection_t ZERO_ERR = '{default: '0, divide_error: 1'b1};
	localparam projection_t ZERO_ERR_NEAR = '{default: '0, divide_error: 1'b1,
		near_flag: 1'b1};
	localparam logic signed [17:0] ONE = 18'sh10000;
	localparam logic signed [17:0] VMAX = 18'sh1FFFF;
	localparam logic signed [17:0] VMIN = 18'sh20000;

	// Directed rows. Typed-in results: all-zero vectors, a flat camera and a
	// sprite on the camera give a divide error; a sprite on the camera is near.
	directed_row_t directed_rows[] = '{
		'{'{32'h0, 32'h0, 32'h0, 32'h0, 18'sd0, 18'sd0, 18'sd0, 18'sd0}, 1, ZERO_ERR_NEAR},
		'{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
			1, ZERO_ERR},
		'{'{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ONE, ONE, ONE, ONE}, 1, ZERO_ERR},
		'{'{32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
			ONE, 18'sd0, 18'sd0, ONE}, 1, ZERO_ERR_NEAR},
		// Sprites ahead, behind and to the side at various depths, standard camera.
		'{'{32'h0005_0000, 32'h0008_0000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'h0005_0000, 32'h0005_8000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'h0005_0000, 32'h0005_0001, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'h0005_0000, 32'h0004_0000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'h0009_0000, 32'h0006_0000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'h0001_0000, 32'h0006_0000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		// Extreme offsets and vectors: saturation of depth and column.
		'{'{32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, VMAX, VMIN, VMIN, VMAX}, 0, '0},
		'{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 18'sd1, 18'sd0, 18'sd0, 18'sd1},
			0, '0},
		'{'{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, VMIN, VMAX, VMAX, VMIN}, 0, '0},
		'{'{32'h0000_0001, 32'h0000_0000, 32'h0, 32'h0, VMIN, 18'sd1, 18'sd1, VMAX}, 0, '0},
		'{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			VMAX, VMAX, VMIN, VMAX}, 0, '0},
		// Near boundary around 2.0 and the squared length wrapping.
		'{'{32'h0007_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'h0006_FFFF, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
			18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		'{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 18'sd0, ONE, -ONE, 18'sd0}, 0, '0},
		// Far off to the side: the column saturates high and low.
		'{'{32'h0000_0001, 32'h0000_0010, 32'h4000_0000, 32'h0, 18'sd0, ONE, -ONE, 18'sd0},
			0, '0},
		'{'{32'hFFFF_0000, 32'h0000_0010, 32'h0, 32'h0, 18'sd0, ONE, -ONE, 18'sd0}, 0, '0}
	};

	initial begin
		logic [31:0] near_settings[5];
		near_settings = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0040_0000,
			NEAR_RESET};
		near_dist_model = NEAR_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sprite(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].proj);
		wait_drained();

		// Random sprites in phases, each with its own near distance; the
		// extremes make near always false and nearly always true.
		for (int ph = 0; ph < 5; ph++) begin
			write_near_distance(near_settings[ph]);
			for (int k = 0; k < N_RANDOM / 5; k++) begin
				send_sprite(rand_sprite(), 0, '0);
				// Once in the run the sender waits for the pipeline to drain.
				if (ph == 2 && k == 50)
					wait_drained();
			end
			wait_drained();
		end

		$display("Covered %0d projections, %0d with a divide error, %0d near,",
			n_results, n_errors_seen, n_near_seen);
		$display("over five near distance settings including both extremes.");
		if (mismatches == 0 && pending_proj.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
